// ===== sv/rrte_pkg.sv =====
`default_nettype none

package rrte_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [4:0] COST_INF = 5'd16;
    localparam logic [4:0] REFRESH_RESET = 5'd15;
    localparam logic [3:0] HOP_COST_RESET = 4'd1;

    localparam logic REG_REFRESH_TIME = 1'b0;
    localparam logic REG_HOP_COST = 1'b1;

    typedef enum logic [2:0] {
        FUNC_TICK = 3'd0,
        FUNC_ADVERT = 3'd1,
        FUNC_LOOKUP = 3'd2,
        FUNC_DUMP = 3'd3,
        FUNC_ADD_LOCAL = 3'd4,
        FUNC_LINK_DOWN = 3'd5,
        FUNC_LINK_UP = 3'd6,
        FUNC_NONE = 3'd7
    } func_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] next_hop;
        logic [4:0] cost;
        logic [4:0] ttl;
        logic is_local;
    } entry_t;

    typedef struct packed {
        func_t func;
        logic [31:0] nbr;
        logic [31:0] loc;
        logic [31:0] dst;
        logic [4:0] new_cost;
        logic adv_inf;
        logic [4:0] refresh;
        logic at_hit;
    } upd_cmd_t;

endpackage

`default_nettype wire

// ===== sv/rrte_entry_upd.sv =====
`default_nettype none

module rrte_entry_upd
    import rrte_pkg::*;
(
    input  wire upd_cmd_t cmd,
    input  wire entry_t   e_in,
    input  wire logic     v_in,
    input  wire logic     m_in,
    output entry_t        e_out,
    output logic          we,
    output logic          chg
);

    logic nh_nbr;
    logic nh_link;
    logic dst_eq;
    logic [4:0] ttl_dec;

    assign nh_nbr = (e_in.next_hop == cmd.nbr);
    assign nh_link = nh_nbr || (e_in.next_hop == cmd.loc);
    assign dst_eq = (e_in.dest == cmd.dst);
    assign ttl_dec = e_in.ttl - 5'd1;

    always_comb
    begin
        e_out = e_in;
        we = 1'b0;
        chg = 1'b0;
        if (v_in)
        begin
            unique case (cmd.func)
                FUNC_TICK:
                begin
                    if (e_in.cost != 5'd0 && e_in.ttl != 5'd0)
                    begin
                        we = 1'b1;
                        e_out.ttl = ttl_dec;
                        if (ttl_dec == 5'd0)
                        begin
                            e_out.cost = COST_INF;
                            chg = 1'b1;
                        end
                    end
                end
                FUNC_ADVERT:
                begin
                    we = 1'b1;
                    if (nh_nbr)
                        e_out.ttl = cmd.refresh;
                    if (!nh_nbr && dst_eq && !e_in.is_local && cmd.new_cost < e_in.cost)
                    begin
                        e_out.next_hop = cmd.nbr;
                        e_out.cost = cmd.new_cost;
                        e_out.ttl = cmd.refresh;
                        chg = 1'b1;
                    end
                    else if (m_in && dst_eq)
                    begin
                        if (cmd.adv_inf)
                        begin
                            if (e_in.cost != COST_INF)
                            begin
                                chg = 1'b1;
                                e_out.ttl = cmd.refresh;
                            end
                            e_out.cost = COST_INF;
                        end
                        else if (e_in.cost != cmd.new_cost)
                        begin
                            e_out.cost = cmd.new_cost;
                            e_out.ttl = cmd.refresh;
                            chg = 1'b1;
                        end
                    end
                end
                FUNC_ADD_LOCAL:
                begin
                    if (cmd.at_hit)
                    begin
                        we = 1'b1;
                        e_out.ttl = cmd.refresh;
                    end
                end
                FUNC_LINK_DOWN:
                begin
                    if (nh_link)
                    begin
                        we = 1'b1;
                        e_out.cost = COST_INF;
                    end
                end
                FUNC_LINK_UP:
                begin
                    if (nh_link)
                    begin
                        we = 1'b1;
                        e_out.cost = 5'd0;
                        e_out.ttl = cmd.refresh;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/rip_route_table_engine_core.sv =====
`default_nettype none

// Lookup runs a find pass over the table; advert entry and add local run a find pass and
// an update pass, and tick, link and dump items one walk pass; no-op items skip the table.
// Throughput: one item at a time; the next one is accepted once idle after the result is
// issued; a pass reads one entry per cycle unless stalled, from the dual-port table RAM.
// Dump results follow at one per cycle, stalling the walk under output backpressure.
// Reset (rst_n low, async) clears valid bits, marks, advert state and restores config
// defaults; table RAM contents are not cleared.

module rip_route_table_engine_core
    import rrte_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // neighbor_addr[31:0], local_addr[63:32], dest_addr[95:64], adv_cost[100:96], zeros
    input  wire logic [103:0] s_tdata,
    // func[2:0]
    input  wire logic [2:0]   s_tuser,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // route_dest[31:0], route_cost[36:32], next_hop[68:37], found[69], changed[70],
    // table_full[71]
    output logic [71:0]       m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_we,
    input  wire logic         cfg_addr,
    input  wire logic [4:0]   cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [4:0] refresh_reg;
    logic [3:0] hop_cost_reg;

    func_t func_reg;
    logic [31:0] nbr_reg, loc_reg, dst_reg;
    logic [4:0] adv_reg;
    logic last_entry_reg;

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] mark_reg, mark_next;
    logic advert_open_reg, advert_open_next;
    logic adv_chg_reg, adv_chg_next;
    logic open_now_reg, open_now_next;
    logic item_chg_reg, item_chg_next;

    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic p_vld_reg, p_vld_next;
    logic [IDX_W-1:0] p_idx_reg, p_idx_next;

    logic hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [4:0] res_cost_reg, res_cost_next;
    logic [31:0] res_nh_reg, res_nh_next;
    logic dump_any_reg, dump_any_next;

    logic out_valid_reg, out_valid_next;
    logic [71:0] out_data_reg, out_data_next;
    logic out_last_reg, out_last_next;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_q;
    logic mem_re, mem_we;
    entry_t mem_wd;

    logic [4:0] adv_clamp;
    logic [5:0] nc_sum;
    logic [4:0] nc;
    logic accept;
    logic stall, fire, pass_end, issue;
    logic insert, ins_here, v_cur, m_cur;
    logic [IDX_W-1:0] tgt_idx;
    logic dump_last, emit_dump;
    logic [TABLE_DEPTH-1:0] valid_above;
    entry_t new_e, e_cur, e_upd;
    logic upd_we, upd_chg;
    upd_cmd_t cmd;
    logic [4:0] dump_cost;

    assign adv_clamp = (adv_reg > COST_INF) ? COST_INF : adv_reg;
    assign nc_sum = {1'b0, adv_clamp} + {2'b00, hop_cost_reg};
    assign nc = (nc_sum > {1'b0, COST_INF}) ? COST_INF : nc_sum[4:0];

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tlast = out_last_reg;

    assign insert = !hit_reg && free_reg;
    assign ins_here = insert && (p_idx_reg == free_idx_reg) && (state_reg == ST_WALK);
    assign tgt_idx = hit_reg ? hit_idx_reg : free_idx_reg;

    assign new_e.dest = dst_reg;
    assign new_e.next_hop = nbr_reg;
    assign new_e.cost = (func_reg == FUNC_ADD_LOCAL) ? adv_clamp : nc;
    assign new_e.ttl = refresh_reg;
    assign new_e.is_local = (func_reg == FUNC_ADD_LOCAL);

    assign e_cur = ins_here ? new_e : rd_q;
    assign v_cur = valid_reg[p_idx_reg] || ins_here;
    assign m_cur = mark_reg[p_idx_reg] && !ins_here;

    assign cmd.func = func_reg;
    assign cmd.nbr = nbr_reg;
    assign cmd.loc = loc_reg;
    assign cmd.dst = dst_reg;
    assign cmd.new_cost = nc;
    assign cmd.adv_inf = (adv_clamp == COST_INF);
    assign cmd.refresh = refresh_reg;
    assign cmd.at_hit = hit_reg && (p_idx_reg == hit_idx_reg);

    rrte_entry_upd u_upd (
        .cmd   (cmd),
        .e_in  (e_cur),
        .v_in  (v_cur),
        .m_in  (m_cur),
        .e_out (e_upd),
        .we    (upd_we),
        .chg   (upd_chg)
    );

    assign valid_above = valid_reg >> p_idx_reg;
    assign dump_last = ((valid_above >> 1) == '0);
    assign dump_cost = (rd_q.next_hop == nbr_reg && rd_q.cost != 5'd0) ? COST_INF : rd_q.cost;

    assign stall = p_vld_reg && (state_reg == ST_WALK) && (func_reg == FUNC_DUMP)
                   && valid_reg[p_idx_reg] && out_valid_reg && !m_tready;
    assign fire = p_vld_reg && !stall;
    assign pass_end = fire && (p_idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign issue = (state_reg == ST_SCAN || state_reg == ST_WALK)
                   && (rd_idx_reg < CNT_W'(TABLE_DEPTH)) && !stall;
    assign emit_dump = fire && (state_reg == ST_WALK) && (func_reg == FUNC_DUMP)
                       && valid_reg[p_idx_reg];

    assign mem_re = issue;
    assign mem_we = fire && (state_reg == ST_WALK) && (upd_we || ins_here);
    assign mem_wd = e_upd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[p_idx_reg] <= mem_wd;
        if (mem_re)
            rd_q <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        mark_next = mark_reg;
        advert_open_next = advert_open_reg;
        adv_chg_next = adv_chg_reg;
        open_now_next = open_now_reg;
        item_chg_next = item_chg_reg;
        rd_idx_next = rd_idx_reg;
        p_vld_next = p_vld_reg;
        p_idx_next = p_idx_reg;
        hit_next = hit_reg;
        hit_idx_next = hit_idx_reg;
        free_next = free_reg;
        free_idx_next = free_idx_reg;
        res_cost_next = res_cost_reg;
        res_nh_next = res_nh_reg;
        dump_any_next = dump_any_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;

        if (!stall)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(issue);
            p_vld_next = issue;
            p_idx_next = rd_idx_reg[IDX_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_next = 1'b0;
                    free_next = 1'b0;
                    item_chg_next = 1'b0;
                    dump_any_next = 1'b0;
                    open_now_next = 1'b0;
                    rd_idx_next = '0;
                    p_vld_next = 1'b0;
                    if (func_t'(s_tuser) == FUNC_ADVERT && !advert_open_reg)
                    begin
                        open_now_next = 1'b1;
                        advert_open_next = 1'b1;
                        adv_chg_next = 1'b0;
                    end
                    unique case (func_t'(s_tuser))
                        FUNC_ADVERT, FUNC_LOOKUP, FUNC_ADD_LOCAL: state_next = ST_SCAN;
                        FUNC_NONE: state_next = ST_DONE;
                        default: state_next = ST_WALK;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (fire)
                begin
                    if (!hit_reg && valid_reg[p_idx_reg] && rd_q.dest == dst_reg)
                    begin
                        hit_next = 1'b1;
                        hit_idx_next = p_idx_reg;
                        res_cost_next = rd_q.cost;
                        res_nh_next = rd_q.next_hop;
                    end
                    if (!free_reg && !valid_reg[p_idx_reg])
                    begin
                        free_next = 1'b1;
                        free_idx_next = p_idx_reg;
                    end
                    if (open_now_reg)
                        mark_next[p_idx_reg] = valid_reg[p_idx_reg]
                                               && (rd_q.next_hop == nbr_reg);
                end
                if (pass_end)
                begin
                    rd_idx_next = '0;
                    p_vld_next = 1'b0;
                    state_next = (func_reg == FUNC_LOOKUP) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (fire)
                begin
                    if (ins_here)
                    begin
                        valid_next[p_idx_reg] = 1'b1;
                        mark_next[p_idx_reg] = 1'b0;
                    end
                    if (func_reg == FUNC_ADVERT)
                        adv_chg_next = adv_chg_reg || upd_chg || ins_here;
                    else
                        item_chg_next = item_chg_reg || upd_chg || ins_here;
                    if ((hit_reg || insert) && p_idx_reg == tgt_idx)
                    begin
                        res_cost_next = e_upd.cost;
                        res_nh_next = e_upd.next_hop;
                    end
                end
                if (emit_dump)
                begin
                    dump_any_next = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next = {3'b001, rd_q.next_hop, dump_cost, rd_q.dest};
                    out_last_next = dump_last;
                end
                if (pass_end)
                begin
                    rd_idx_next = '0;
                    p_vld_next = 1'b0;
                    if (func_reg == FUNC_DUMP && (dump_any_reg || emit_dump))
                        state_next = ST_IDLE;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_last_next = 1'b1;
                    state_next = ST_IDLE;
                    unique case (func_reg)
                        FUNC_TICK:
                            out_data_next = {1'b0, item_chg_reg, 70'd0};
                        FUNC_ADVERT:
                        begin
                            if (hit_reg || insert)
                                out_data_next = {!hit_reg && !free_reg, adv_chg_reg, 1'b1,
                                                 res_nh_reg, res_cost_reg, dst_reg};
                            else
                                out_data_next = {!hit_reg && !free_reg, adv_chg_reg, 1'b0,
                                                 32'd0, 5'd0, dst_reg};
                            if (last_entry_reg)
                            begin
                                advert_open_next = 1'b0;
                                adv_chg_next = 1'b0;
                            end
                        end
                        FUNC_LOOKUP:
                        begin
                            if (hit_reg)
                                out_data_next = {3'b001, res_nh_reg, res_cost_reg, dst_reg};
                            else
                                out_data_next = {3'b000, 32'hFFFF_FFFF, COST_INF, dst_reg};
                        end
                        FUNC_ADD_LOCAL:
                        begin
                            if (hit_reg || insert)
                                out_data_next = {1'b0, item_chg_reg, 1'b1,
                                                 res_nh_reg, res_cost_reg, dst_reg};
                            else
                                out_data_next = {1'b1, 2'b00, 32'd0, 5'd0, dst_reg};
                        end
                        FUNC_LINK_DOWN, FUNC_LINK_UP:
                            out_data_next = {3'b010, 69'd0};
                        default:
                            out_data_next = '0;
                    endcase
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            refresh_reg <= REFRESH_RESET;
            hop_cost_reg <= HOP_COST_RESET;
            valid_reg <= '0;
            mark_reg <= '0;
            advert_open_reg <= 1'b0;
            adv_chg_reg <= 1'b0;
            open_now_reg <= 1'b0;
            item_chg_reg <= 1'b0;
            rd_idx_reg <= '0;
            p_vld_reg <= 1'b0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            dump_any_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_REFRESH_TIME: refresh_reg <= cfg_wdata;
                    REG_HOP_COST: hop_cost_reg <= cfg_wdata[3:0];
                    default: refresh_reg <= refresh_reg;
                endcase
            end
            valid_reg <= valid_next;
            mark_reg <= mark_next;
            advert_open_reg <= advert_open_next;
            adv_chg_reg <= adv_chg_next;
            open_now_reg <= open_now_next;
            item_chg_reg <= item_chg_next;
            rd_idx_reg <= rd_idx_next;
            p_vld_reg <= p_vld_next;
            hit_reg <= hit_next;
            free_reg <= free_next;
            dump_any_reg <= dump_any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(s_tuser);
            nbr_reg <= s_tdata[31:0];
            loc_reg <= s_tdata[63:32];
            dst_reg <= s_tdata[95:64];
            adv_reg <= s_tdata[100:96];
            last_entry_reg <= s_tlast;
        end
        p_idx_reg <= p_idx_next;
        hit_idx_reg <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        res_cost_reg <= res_cost_next;
        res_nh_reg <= res_nh_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

`ifndef NO_ASSERTIONS
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !mem_we)
        else $error("table written during find pass");

    a_pipe_only_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        p_vld_reg |-> (state_reg == ST_SCAN || state_reg == ST_WALK))
        else $error("pass pipeline active outside a pass");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input ready right after a transaction");

    a_stall_holds_index: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> $stable(p_idx_reg))
        else $error("walk advanced while output stalled");
`endif

endmodule

`default_nettype wire

// ===== test/rip_route_table_engine_core_tb.sv =====
`default_nettype none

module rip_route_table_engine_core_tb
    import rrte_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = TABLE_DEPTH;

    typedef struct {
        logic [31:0] dest;
        logic [4:0]  cost;
        logic [31:0] hop;
        logic        found;
        logic        changed;
        logic        full;
        logic        last;
    } route_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [103:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic m_tlast;
    logic cfg_we = 1'b0;
    logic cfg_addr = 1'b0;
    logic [4:0] cfg_wdata = '0;

    rip_route_table_engine_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow route table
    logic        t_valid [DEPTH];
    logic [31:0] t_dest [DEPTH];
    logic [31:0] t_hop [DEPTH];
    logic [4:0]  t_cost [DEPTH];
    logic [4:0]  t_ttl [DEPTH];
    logic        t_local [DEPTH];
    logic        t_mark [DEPTH];
    logic        adv_open;
    logic        adv_chg;
    logic [4:0]  ttl_load;
    logic [3:0]  hop_add;

    route_rsp_t pending_routes[$];
    int errors = 0;
    int mismatches = 0;
    bit rx_hold = 1'b0;
    bit rx_random = 1'b1;
    bit tx_random = 1'b1;

    // addresses drawn from a small pool so that hits, next hop matches and links collide
    logic [31:0] addr_pool [8];

    function automatic int find_route(logic [31:0] d);
        for (int i = 0; i < DEPTH; i++)
            if (t_valid[i] && t_dest[i] == d)
                return i;
        return -1;
    endfunction

    function automatic int find_slot();
        for (int i = 0; i < DEPTH; i++)
            if (!t_valid[i])
                return i;
        return -1;
    endfunction

    function automatic void push_rsp(logic [31:0] d, logic [4:0] c, logic [31:0] h,
                                     logic f, logic ch, logic fu, logic l);
        route_rsp_t r;
        r.dest = d; r.cost = c; r.hop = h; r.found = f;
        r.changed = ch; r.full = fu; r.last = l;
        pending_routes.push_back(r);
    endfunction

    function automatic void predict_route(func_t fn, logic [31:0] nbr, logic [31:0] loc,
                                          logic [31:0] dst, logic [4:0] adv_in, logic lst);
        logic [4:0] adv;
        logic [4:0] nc;
        logic chg;
        logic full;
        int i;
        int f;
        int k;
        logic [4:0] c;
        adv = (adv_in > COST_INF) ? COST_INF : adv_in;
        chg = 1'b0;
        full = 1'b0;
        case (fn)
            FUNC_TICK:
            begin
                for (i = 0; i < DEPTH; i++)
                    if (t_valid[i] && t_cost[i] != 0 && t_ttl[i] != 0)
                    begin
                        t_ttl[i] = t_ttl[i] - 5'd1;
                        if (t_ttl[i] == 0)
                        begin
                            t_cost[i] = COST_INF;
                            chg = 1'b1;
                        end
                    end
                push_rsp(0, 0, 0, 0, chg, 0, 1);
            end
            FUNC_ADVERT:
            begin
                nc = ({1'b0, adv} + {2'b0, hop_add} > 6'd16) ? COST_INF : adv + hop_add;
                if (!adv_open)
                begin
                    for (i = 0; i < DEPTH; i++)
                        t_mark[i] = t_valid[i] && t_hop[i] == nbr;
                    adv_open = 1'b1;
                    adv_chg = 1'b0;
                end
                if (find_route(dst) < 0)
                begin
                    f = find_slot();
                    if (f < 0)
                        full = 1'b1;
                    else
                    begin
                        t_valid[f] = 1'b1; t_dest[f] = dst; t_hop[f] = nbr;
                        t_cost[f] = nc; t_ttl[f] = ttl_load;
                        t_local[f] = 1'b0; t_mark[f] = 1'b0;
                        adv_chg = 1'b1;
                    end
                end
                for (i = 0; i < DEPTH; i++)
                begin
                    if (!t_valid[i])
                        continue;
                    if (t_hop[i] == nbr)
                        t_ttl[i] = ttl_load;
                    if (t_hop[i] != nbr && t_dest[i] == dst && !t_local[i] && nc < t_cost[i])
                    begin
                        t_hop[i] = nbr; t_cost[i] = nc; t_ttl[i] = ttl_load;
                        adv_chg = 1'b1;
                    end
                    else if (t_mark[i] && t_dest[i] == dst)
                    begin
                        if (adv == COST_INF)
                        begin
                            if (t_cost[i] != COST_INF)
                            begin
                                adv_chg = 1'b1;
                                t_ttl[i] = ttl_load;
                            end
                            t_cost[i] = COST_INF;
                        end
                        else if (t_cost[i] != nc)
                        begin
                            t_cost[i] = nc; t_ttl[i] = ttl_load;
                            adv_chg = 1'b1;
                        end
                    end
                end
                i = find_route(dst);
                if (i >= 0)
                    push_rsp(dst, t_cost[i], t_hop[i], 1, adv_chg, full, 1);
                else
                    push_rsp(dst, 0, 0, 0, adv_chg, full, 1);
                if (lst)
                begin
                    adv_open = 1'b0;
                    adv_chg = 1'b0;
                end
            end
            FUNC_LOOKUP:
            begin
                i = find_route(dst);
                if (i >= 0)
                    push_rsp(dst, t_cost[i], t_hop[i], 1, 0, 0, 1);
                else
                    push_rsp(dst, COST_INF, '1, 0, 0, 0, 1);
            end
            FUNC_DUMP:
            begin
                k = 0;
                for (i = 0; i < DEPTH; i++)
                begin
                    if (!t_valid[i])
                        continue;
                    c = t_cost[i];
                    if (t_hop[i] == nbr && c != 0)
                        c = COST_INF;
                    push_rsp(t_dest[i], c, t_hop[i], 1, 0, 0, 0);
                    k++;
                end
                if (k == 0)
                    push_rsp(0, 0, 0, 0, 0, 0, 1);
                else
                    pending_routes[$].last = 1'b1;
            end
            FUNC_ADD_LOCAL:
            begin
                i = find_route(dst);
                if (i >= 0)
                    t_ttl[i] = ttl_load;
                else
                begin
                    i = find_slot();
                    if (i < 0)
                        full = 1'b1;
                    else
                    begin
                        t_valid[i] = 1'b1; t_dest[i] = dst; t_hop[i] = nbr;
                        t_cost[i] = adv; t_ttl[i] = ttl_load;
                        t_local[i] = 1'b1; t_mark[i] = 1'b0;
                        chg = 1'b1;
                    end
                end
                if (i >= 0)
                    push_rsp(dst, t_cost[i], t_hop[i], 1, chg, 0, 1);
                else
                    push_rsp(dst, 0, 0, 0, 0, full, 1);
            end
            FUNC_LINK_DOWN, FUNC_LINK_UP:
            begin
                for (i = 0; i < DEPTH; i++)
                    if (t_valid[i] && (t_hop[i] == loc || t_hop[i] == nbr))
                    begin
                        if (fn == FUNC_LINK_DOWN)
                            t_cost[i] = COST_INF;
                        else
                        begin
                            t_cost[i] = 0;
                            t_ttl[i] = ttl_load;
                        end
                    end
                push_rsp(0, 0, 0, 0, 1, 0, 1);
            end
            default:
                push_rsp(0, 0, 0, 0, 0, 0, 1);
        endcase
    endfunction

    task automatic tx_gap();
        if (tx_random && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 14)) @(posedge clk);
    endtask

    task automatic send_route_item(func_t fn, logic [31:0] nbr, logic [31:0] loc,
                                   logic [31:0] dst, logic [4:0] adv, logic lst);
        tx_gap();
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tlast <= lst;
        s_tdata <= {3'b0, adv, dst, loc, nbr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_route(fn, nbr, loc, dst, adv, lst);
        s_tvalid <= 1'b0;
        // block is busy after a transaction; all functions but FUNC_NONE run a full table pass
        @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_REFRESH_TIME)
            ttl_load = val;
        else
            hop_add = val[3:0];
    endtask

    task automatic drain();
        while (pending_routes.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_addr();
        return ($urandom_range(0, 4) == 0) ? $urandom : addr_pool[3'($urandom_range(0, 7))];
    endfunction

    function automatic logic [4:0] pick_cost();
        return ($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 16));
    endfunction

    // response checker
    always @(posedge clk)
    begin
        route_rsp_t e;
        if (m_tvalid && m_tready)
        begin
            if (pending_routes.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected transaction %h last %b", m_tdata, m_tlast);
            end
            else
            begin
                e = pending_routes.pop_front();
                if (m_tdata[31:0] !== e.dest || m_tdata[36:32] !== e.cost
                    || m_tdata[68:37] !== e.hop || m_tdata[69] !== e.found
                    || m_tdata[70] !== e.changed || m_tdata[71] !== e.full
                    || m_tlast !== e.last)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp %h %0d %h f%b c%b u%b l%b got %h l%b",
                                 e.dest, e.cost, e.hop, e.found, e.changed, e.full,
                                 e.last, m_tdata, m_tlast);
                end
            end
        end
    end

    // receiver backpressure
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (rx_hold)
                m_tready <= 1'b0;
            else if (rx_random && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 14);
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_route_item(FUNC_DUMP, addr_pool[0], 0, 0, 0, 1);
        send_route_item(FUNC_LOOKUP, 0, 0, '1, 0, 1);
        send_route_item(FUNC_TICK, 0, 0, 0, 0, 1);
        send_route_item(FUNC_NONE, '1, '1, '1, 5'h1f, 1);
        send_route_item(FUNC_ADD_LOCAL, 32'h0, 0, '1, 5'd31, 1);
        send_route_item(FUNC_ADD_LOCAL, 32'h0, 0, '1, 5'd3, 1);
        send_route_item(FUNC_ADVERT, addr_pool[0], 0, addr_pool[1], 0, 0);
        send_route_item(FUNC_ADVERT, addr_pool[0], 0, addr_pool[2], 16, 0);
        send_route_item(FUNC_ADVERT, addr_pool[0], 0, addr_pool[3], 15, 1);
        send_route_item(FUNC_ADVERT, addr_pool[1], 0, addr_pool[3], 2, 1);
        send_route_item(FUNC_ADVERT, addr_pool[0], 0, addr_pool[1], 5, 0);
        send_route_item(FUNC_ADVERT, addr_pool[0], 0, addr_pool[2], 16, 1);
        send_route_item(FUNC_DUMP, addr_pool[0], 0, 0, 0, 1);
        repeat (3) send_route_item(FUNC_TICK, 0, 0, 0, 0, 1);
        send_route_item(FUNC_LINK_DOWN, addr_pool[1], addr_pool[0], 0, 0, 1);
        send_route_item(FUNC_LOOKUP, 0, 0, addr_pool[3], 0, 1);
        send_route_item(FUNC_LINK_UP, '1, addr_pool[0], 0, 0, 1);
        send_route_item(FUNC_DUMP, '1, 0, 0, 0, 1);
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_REFRESH_TIME, 5'd1);
        write_reg(REG_HOP_COST, 5'd15);
        send_route_item(FUNC_ADVERT, addr_pool[4], 0, addr_pool[5], 1, 1);
        send_route_item(FUNC_TICK, 0, 0, 0, 0, 1);
        send_route_item(FUNC_TICK, 0, 0, 0, 0, 1);
        drain();
        write_reg(REG_REFRESH_TIME, 5'd0);
        send_route_item(FUNC_ADVERT, addr_pool[6], 0, addr_pool[7], 0, 1);
        send_route_item(FUNC_TICK, 0, 0, 0, 0, 1);
        drain();
        write_reg(REG_REFRESH_TIME, 5'd31);
        write_reg(REG_HOP_COST, 5'd1);
        drain();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < DEPTH + 2; i++)
            send_route_item(($urandom_range(0, 1) != 0) ? FUNC_ADVERT : FUNC_ADD_LOCAL,
                            pick_addr(), 0, $urandom, pick_cost(), 1);
        send_route_item(FUNC_DUMP, addr_pool[3'($urandom_range(0, 7))], 0, 0, 0, 1);
        drain();
    endtask

    task automatic random_phase(int n);
        int left;
        logic [31:0] nbr;
        left = n;
        while (left > 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    nbr = pick_addr();
                    for (int j = $urandom_range(1, 4); j > 0 && left > 0; j--)
                    begin
                        send_route_item(FUNC_ADVERT, nbr, 0, pick_addr(), pick_cost(),
                                        j == 1);
                        left--;
                    end
                end
                4:
                begin
                    send_route_item(FUNC_TICK, 0, 0, 0, 0, 1'($urandom));
                    left--;
                end
                5:
                begin
                    send_route_item(FUNC_LOOKUP, $urandom, $urandom, pick_addr(),
                                    5'($urandom), 1'($urandom));
                    left--;
                end
                6:
                begin
                    send_route_item(FUNC_DUMP, pick_addr(), $urandom, $urandom, 0, 1);
                    left--;
                end
                7:
                begin
                    send_route_item(FUNC_ADD_LOCAL, pick_addr(), 0, pick_addr(), pick_cost(),
                                    1);
                    left--;
                end
                default:
                begin
                    send_route_item(func_t'($urandom_range(5, 7)), pick_addr(), pick_addr(),
                                    $urandom, 5'($urandom), 1'($urandom));
                    left--;
                end
            endcase
        end
    endtask

    task automatic test_random();
        write_reg(REG_REFRESH_TIME, 5'($urandom_range(2, 20)));
        write_reg(REG_HOP_COST, 5'($urandom_range(1, 15)));
        random_phase(25);
        drain();
        write_reg(REG_REFRESH_TIME, 5'd15);
        write_reg(REG_HOP_COST, 5'($urandom_range(1, 4)));
        random_phase(15);
        drain();
    endtask

    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                rx_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 8; i++)
                    send_route_item(FUNC_DUMP, addr_pool[3'($urandom_range(0, 7))], 0, 0, 0,
                                    1);
            end
        join
        drain();
    endtask

    task automatic test_no_idle();
        rx_random = 1'b0;
        tx_random = 1'b0;
        random_phase(15);
        drain();
    endtask

    initial
    begin
        foreach (addr_pool[i])
            addr_pool[i] = $urandom;
        addr_pool[0] = 32'h0;
        addr_pool[7] = 32'hffff_ffff;
        foreach (t_valid[i])
        begin
            t_valid[i] = 1'b0;
            t_mark[i] = 1'b0;
        end
        adv_open = 1'b0;
        adv_chg = 1'b0;
        ttl_load = REFRESH_RESET;
        hop_add = HOP_COST_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_table_full();
        test_random();
        test_backpressure();
        test_no_idle();
        if (errors == 0 && pending_routes.size() == 0)
            $display("rip_route_table_engine_core test passed");
        else
            $display("rip_route_table_engine_core test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("rip_route_table_engine_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
